// ===== src/bba_pkg.sv =====
// Shared types and codes of the buddy block allocator.
package bba_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOMEM = 2'd1;
    localparam logic [1:0] STATUS_ORDER = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_POP,
        S_A_GIVE,
        S_A_TAKE,
        S_A_SPLIT,
        S_F_CHECK,
        S_F_WALK,
        S_F_CMP,
        S_F_GIVE,
        S_F_PUSH,
        S_F_LINK
    } t_state;

endpackage

// ===== src/bba_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/buddy_block_allocator_unit.sv =====
// Buddy block allocator with free lists kept in a node memory.
//
// Channel   Direction  Signals
// command   in         start, busy, i_cmd, i_req_order, i_block_index
// result    out        o_done, o_status, o_block_out
// config    in         i_cfg_we, i_cfg_data
//
// Every list step is one read of the node memory and one write back.
// An allocation pops the head node and gives it back to the spare chain, then takes one
// spare node per split level; a free walks each buddy search node by node, unlinks the
// buddy on a merge, and ends with a push of the block onto its list.
// A request rejected at acceptance gives its beat on the next cycle.
// After reset and after every configuration write, a clearing pass over all NODE_COUNT nodes
// rebuilds the spare node chain while busy stays high.
// The result beat is shown for one cycle on o_done; the receiver cannot stall it.
module buddy_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_ORDER  = 10,
    parameter int NODE_COUNT = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cmd,
    input  logic [$clog2(MAX_ORDER+1)-1:0]   i_req_order,
    input  logic [MAX_ORDER-1:0]             i_block_index,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [MAX_ORDER-1:0]             o_block_out,
    input  logic                             i_cfg_we,
    input  logic [$clog2(MAX_ORDER+1)-1:0]   i_cfg_data
);

    localparam int OW   = $clog2(MAX_ORDER + 1);
    localparam int BW   = MAX_ORDER;
    localparam int NW   = $clog2(NODE_COUNT);
    localparam int CW   = $clog2(NODE_COUNT + 1);
    localparam int MW   = BW + 1 + NW;
    localparam int DW   = (CW > OW) ? CW : OW;
    localparam int RST_ORDER = (10 > MAX_ORDER) ? MAX_ORDER : 10;

    t_state r_state, n_state;

    logic [OW-1:0] r_total;
    logic [NW-1:0] r_head [MAX_ORDER+1];
    logic [MAX_ORDER:0] r_head_ok;
    logic [NW-1:0] r_spare_head;
    logic          r_spare_ok;
    logic [CW-1:0] r_spare_cnt;
    logic [NW-1:0] r_clr;

    logic [OW-1:0] r_ord;
    logic [OW-1:0] r_lvl;
    logic [BW-1:0] r_blk;
    logic [NW-1:0] r_node;
    logic [NW-1:0] r_cur;
    logic          r_cur_ok;
    logic [BW-1:0] r_cur_blk;
    logic [NW-1:0] r_prev;
    logic [BW-1:0] r_prev_blk;
    logic          r_have_prev;
    logic [CW-1:0] r_guard;

    logic          r_done;
    logic [1:0]    r_status;
    logic [BW-1:0] r_result;

    logic          m_we;
    logic [NW-1:0] m_waddr;
    logic [MW-1:0] m_wdata;
    logic [NW-1:0] m_raddr;
    logic [MW-1:0] m_rdata;

    logic [BW-1:0] rd_blk;
    logic          rd_ok;
    logic [NW-1:0] rd_nxt;

    logic          w_accept;
    logic          w_found;
    logic [OW-1:0] w_end;
    logic [OW-1:0] w_need;
    logic          w_fail_ord;
    logic          w_fail_mem;
    logic [BW-1:0] w_free_blk;
    logic [OW-1:0] w_lvl_m1;
    logic [BW-1:0] w_lvl_bit;
    logic [BW-1:0] w_half_bit;
    logic          w_match;
    logic [OW-1:0] w_cfg_order;
    logic          w_done;

    bba_ram #(
        .WIDTH(MW),
        .DEPTH(NODE_COUNT)
    ) u_nodes (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    assign rd_blk = m_rdata[MW-1 -: BW];
    assign rd_ok  = m_rdata[NW];
    assign rd_nxt = m_rdata[NW-1:0];

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && (r_state == S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_block_out = r_result;

    assign w_lvl_m1   = r_lvl - 1'b1;
    assign w_lvl_bit  = BW'(1) << r_lvl;
    assign w_half_bit = BW'(1) << w_lvl_m1;
    assign w_match    = (rd_blk == (r_blk ^ w_lvl_bit));

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_order = OW'(1);
        end else if (i_cfg_data > OW'(MAX_ORDER)) begin
            w_cfg_order = OW'(MAX_ORDER);
        end else begin
            w_cfg_order = i_cfg_data;
        end
    end

    always_comb begin
        w_found = 1'b0;
        w_end   = '0;
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if (r_head_ok[k] && (OW'(k) >= i_req_order) && (OW'(k) <= r_total)) begin
                w_found = 1'b1;
                w_end   = OW'(k);
            end
        end
    end

    assign w_need     = w_end - i_req_order - 1'b1;
    assign w_fail_ord = (i_req_order > r_total);
    assign w_fail_mem = !w_found || ((w_end > i_req_order)
                        && (DW'(r_spare_cnt) < DW'(w_need)));
    assign w_free_blk = i_block_index & ~({BW{1'b1}} << r_total)
                        & ({BW{1'b1}} << i_req_order);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == NW'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept && !w_fail_ord) begin
                    if (i_cmd == CMD_FREE) begin
                        n_state = S_F_CHECK;
                    end else if (!w_fail_mem) begin
                        n_state = S_A_POP;
                    end
                end
            end
            S_A_POP:   n_state = S_A_GIVE;
            S_A_GIVE:  n_state = (r_lvl > r_ord) ? S_A_TAKE : S_IDLE;
            S_A_TAKE:  n_state = S_A_SPLIT;
            S_A_SPLIT: n_state = (w_lvl_m1 > r_ord) ? S_A_TAKE : S_IDLE;
            S_F_CHECK: n_state = (r_lvl < r_total) ? S_F_WALK : S_F_PUSH;
            S_F_WALK: begin
                n_state = (r_cur_ok && (r_guard < CW'(NODE_COUNT))) ? S_F_CMP : S_F_PUSH;
            end
            S_F_CMP: begin
                if (!w_match) begin
                    n_state = S_F_WALK;
                end else if (r_have_prev) begin
                    n_state = S_F_GIVE;
                end else begin
                    n_state = S_F_CHECK;
                end
            end
            S_F_GIVE:  n_state = S_F_CHECK;
            S_F_PUSH:  n_state = r_spare_ok ? S_F_LINK : S_IDLE;
            S_F_LINK:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_done = w_accept && (w_fail_ord || (i_cmd == CMD_ALLOC && w_fail_mem));
            end
            S_A_GIVE:  w_done = !(r_lvl > r_ord);
            S_A_SPLIT: w_done = !(w_lvl_m1 > r_ord);
            S_F_PUSH:  w_done = !r_spare_ok;
            S_F_LINK:  w_done = 1'b1;
            default:   w_done = 1'b0;
        endcase
    end

    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_node;
        m_wdata = '0;
        m_raddr = r_cur;
        unique case (r_state)
            S_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                if (32'(r_clr) + 1 < NODE_COUNT) begin
                    m_wdata = {{BW{1'b0}}, (r_clr != '0), NW'(r_clr + 1'b1)};
                end else begin
                    m_wdata = '0;
                end
            end
            S_A_POP:   m_raddr = r_head[r_lvl];
            S_A_GIVE: begin
                m_we    = 1'b1;
                m_waddr = r_node;
                m_wdata = {rd_blk, r_spare_ok, r_spare_head};
            end
            S_A_TAKE:  m_raddr = r_spare_head;
            S_A_SPLIT: begin
                m_we    = 1'b1;
                m_waddr = r_node;
                m_wdata = {r_blk + w_half_bit, r_head_ok[w_lvl_m1], r_head[w_lvl_m1]};
            end
            S_F_WALK:  m_raddr = r_cur;
            S_F_CMP: begin
                if (w_match) begin
                    m_we = 1'b1;
                    if (r_have_prev) begin
                        m_waddr = r_prev;
                        m_wdata = {r_prev_blk, rd_ok, rd_nxt};
                    end else begin
                        m_waddr = r_cur;
                        m_wdata = {rd_blk, r_spare_ok, r_spare_head};
                    end
                end
            end
            S_F_GIVE: begin
                m_we    = 1'b1;
                m_waddr = r_cur;
                m_wdata = {r_cur_blk, r_spare_ok, r_spare_head};
            end
            S_F_PUSH:  m_raddr = r_spare_head;
            S_F_LINK: begin
                m_we    = 1'b1;
                m_waddr = r_node;
                m_wdata = {r_blk, r_head_ok[r_lvl], r_head[r_lvl]};
            end
            default: begin
                m_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_done <= i_rst_n && !i_cfg_we && w_done;
        if (!i_rst_n || i_cfg_we) begin
            r_total <= i_rst_n ? w_cfg_order : OW'(RST_ORDER);
            for (int k = 0; k <= MAX_ORDER; k++) begin
                r_head[k] <= '0;
            end
            r_head_ok <= (MAX_ORDER + 1)'(1) << (i_rst_n ? w_cfg_order : OW'(RST_ORDER));
            r_spare_head <= NW'(1);
            r_spare_ok   <= 1'b1;
            r_spare_cnt  <= CW'(NODE_COUNT - 1);
            r_clr        <= '0;
            r_state      <= S_CLEAR;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_ord <= i_req_order;
                        r_blk <= w_free_blk;
                        r_lvl <= (i_cmd == CMD_FREE) ? i_req_order : w_end;
                        if (w_fail_ord) begin
                            r_status <= STATUS_ORDER;
                            r_result <= '0;
                        end else if (i_cmd == CMD_ALLOC && w_fail_mem) begin
                            r_status <= STATUS_NOMEM;
                            r_result <= '0;
                        end
                    end
                end
                S_A_POP: begin
                    r_node <= r_head[r_lvl];
                end
                S_A_GIVE: begin
                    r_blk            <= rd_blk;
                    r_head[r_lvl]    <= rd_nxt;
                    r_head_ok[r_lvl] <= rd_ok;
                    r_spare_head     <= r_node;
                    r_spare_ok       <= 1'b1;
                    r_spare_cnt      <= r_spare_cnt + 1'b1;
                    if (!(r_lvl > r_ord)) begin
                        r_status <= STATUS_OK;
                        r_result <= rd_blk;
                    end
                end
                S_A_TAKE: begin
                    r_node <= r_spare_head;
                end
                S_A_SPLIT: begin
                    r_spare_ok          <= rd_ok;
                    r_spare_head        <= rd_nxt;
                    r_spare_cnt         <= r_spare_cnt - 1'b1;
                    r_head[w_lvl_m1]    <= r_node;
                    r_head_ok[w_lvl_m1] <= 1'b1;
                    r_lvl               <= w_lvl_m1;
                    if (!(w_lvl_m1 > r_ord)) begin
                        r_status <= STATUS_OK;
                        r_result <= r_blk;
                    end
                end
                S_F_CHECK: begin
                    r_cur       <= r_head[r_lvl];
                    r_cur_ok    <= r_head_ok[r_lvl];
                    r_have_prev <= 1'b0;
                    r_guard     <= '0;
                end
                S_F_CMP: begin
                    if (!w_match) begin
                        r_prev      <= r_cur;
                        r_prev_blk  <= rd_blk;
                        r_have_prev <= 1'b1;
                        r_cur       <= rd_nxt;
                        r_cur_ok    <= rd_ok;
                        r_guard     <= r_guard + 1'b1;
                    end else if (r_have_prev) begin
                        r_cur_blk <= rd_blk;
                    end else begin
                        r_head[r_lvl]    <= rd_nxt;
                        r_head_ok[r_lvl] <= rd_ok;
                        r_spare_head     <= r_cur;
                        r_spare_ok       <= 1'b1;
                        r_spare_cnt      <= r_spare_cnt + 1'b1;
                        r_blk            <= r_blk & ~w_lvl_bit;
                        r_lvl            <= r_lvl + 1'b1;
                    end
                end
                S_F_GIVE: begin
                    r_spare_head <= r_cur;
                    r_spare_ok   <= 1'b1;
                    r_spare_cnt  <= r_spare_cnt + 1'b1;
                    r_blk        <= r_blk & ~w_lvl_bit;
                    r_lvl        <= r_lvl + 1'b1;
                end
                S_F_PUSH: begin
                    r_node <= r_spare_head;
                    if (!r_spare_ok) begin
                        r_status <= STATUS_NOMEM;
                        r_result <= '0;
                    end
                end
                S_F_LINK: begin
                    r_spare_ok       <= rd_ok;
                    r_spare_head     <= rd_nxt;
                    r_spare_cnt      <= r_spare_cnt - 1'b1;
                    r_head[r_lvl]    <= r_node;
                    r_head_ok[r_lvl] <= 1'b1;
                    r_status         <= STATUS_OK;
                    r_result         <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
